@@ rtl/psed_pkg.sv @@
package psed_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DELTA_W    = 64;
    localparam int unsigned PROD_W     = DELTA_W + WORD_W;

    localparam int unsigned FRAC_SHIFT  = 16;
    localparam int unsigned ACCEL_SHIFT = 1;

    localparam int unsigned DIV_JERK    = 6;
    localparam int unsigned DIV_SNAP    = 24;
    localparam int unsigned DIV_CRACKLE = 120;

    localparam int unsigned MUL_STAGES  = 4;
    localparam int unsigned DIV_DIGIT_W = 8;
    localparam int unsigned DIV_DIGITS  = DELTA_W / DIV_DIGIT_W;
    localparam int unsigned DIV_STAGES  = DIV_DIGITS + 2;

    typedef struct packed {
        logic        [WORD_W-1:0] seg_duration;
        logic signed [WORD_W-1:0] seg_velocity;
        logic signed [WORD_W-1:0] seg_accel;
        logic signed [WORD_W-1:0] seg_jerk;
        logic signed [WORD_W-1:0] seg_snap;
        logic signed [WORD_W-1:0] seg_crackle;
    } seg_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] end_delta;
    } delta_t;

endpackage

@@ rtl/psed_stream_if.sv @@
interface psed_stream_if #(
    parameter type data_t = logic [63:0]
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ rtl/polynomial_segment_end_delta.sv @@
// throughput: one segment per cycle, set by the fully pipelined 32x32 multiplier
// chains (five chained steps of four stages plus a ten-stage constant divider)
// a result held at the output with ready low stalls the whole pipeline
// reset: asynchronous active low, clears the stage valid bits only
module polynomial_segment_end_delta (
    input  logic          clk,
    input  logic          rst_n,
    psed_stream_if.sink   seg,
    psed_stream_if.source delta
);

    localparam int unsigned DW  = psed_pkg::DELTA_W;
    localparam int unsigned WW  = psed_pkg::WORD_W;
    localparam int unsigned MS  = psed_pkg::MUL_STAGES;
    localparam int unsigned DS  = psed_pkg::DIV_STAGES;
    localparam int unsigned PW2 = 2 * WW + 2;

    localparam int unsigned VEL_AT   = 1;
    localparam int unsigned ACC_AT   = 1 + MS;
    localparam int unsigned JERK_AT  = 3 * MS + DS;
    localparam int unsigned SNAP_AT  = 4 * MS + DS;
    localparam int unsigned CRK_AT   = 5 * MS + DS;
    localparam int unsigned ALIGN_AT = CRK_AT;
    localparam int unsigned OUT_AT   = ALIGN_AT + 3;

    localparam int unsigned VEL_DLY  = ALIGN_AT - VEL_AT;
    localparam int unsigned ACC_DLY  = ALIGN_AT - ACC_AT;
    localparam int unsigned JERK_DLY = ALIGN_AT - JERK_AT;
    localparam int unsigned SNAP_DLY = ALIGN_AT - SNAP_AT;

    logic en;
    logic vld_reg [0:OUT_AT];

    psed_pkg::seg_t in_reg;

    logic [WW-1:0] t1_reg;
    logic [DW-1:0] vel_reg;
    logic [DW-1:0] acc_reg;

    logic signed [WW:0]       t_s;
    logic signed [2*WW+1:0]   vel_prod;
    logic signed [2*WW+1:0]   acc_prod;

    logic [DW-1:0] acc_term;
    logic [WW-1:0] acc_t;

    logic [DW-1:0] jerk_term;
    logic [DW-1:0] snap_term;
    logic [DW-1:0] crk_term;

    logic [DW-1:0] vel_dly_reg  [0:VEL_DLY-1];
    logic [DW-1:0] acc_dly_reg  [0:ACC_DLY-1];
    logic [DW-1:0] jerk_dly_reg [0:JERK_DLY-1];
    logic [DW-1:0] snap_dly_reg [0:SNAP_DLY-1];

    logic [DW-1:0] sa_reg;
    logic [DW-1:0] sb_reg;
    logic [DW-1:0] sc_reg;
    logic [DW-1:0] sd_reg;
    logic [DW-1:0] se_reg;
    logic [DW-1:0] out_reg;

    assign en        = !vld_reg[OUT_AT] || delta.ready;
    assign seg.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= OUT_AT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= seg.valid;
            for (int i = 1; i <= OUT_AT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= seg.data;
        end
    end

    // velocity and first accel product
    assign t_s      = signed'({1'b0, in_reg.seg_duration});
    assign vel_prod = PW2'(signed'({in_reg.seg_velocity[WW-1], in_reg.seg_velocity}))
                    * PW2'(t_s);
    assign acc_prod = PW2'(signed'({in_reg.seg_accel[WW-1], in_reg.seg_accel}))
                    * PW2'(t_s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= in_reg.seg_duration;
            vel_reg <= vel_prod[DW-1:0] << psed_pkg::FRAC_SHIFT;
            acc_reg <= acc_prod[DW-1:0];
        end
    end

    psed_mul_step #(
        .SHIFT (psed_pkg::ACCEL_SHIFT)
    ) u_acc_step (
        .clk   (clk),
        .en    (en),
        .p_in  (acc_reg),
        .t_in  (t1_reg),
        .p_out (acc_term),
        .t_out (acc_t)
    );

    // jerk chain
    logic [DW-1:0] jp [0:3];
    logic [WW-1:0] jt [0:3];

    assign jp[0] = {{(DW-WW){in_reg.seg_jerk[WW-1]}}, in_reg.seg_jerk};
    assign jt[0] = in_reg.seg_duration;

    for (genvar i = 0; i < 3; i++)
    begin : g_jerk
        psed_mul_step #(
            .SHIFT ((i < 1) ? psed_pkg::FRAC_SHIFT : 0)
        ) u_step (
            .clk   (clk),
            .en    (en),
            .p_in  (jp[i]),
            .t_in  (jt[i]),
            .p_out (jp[i+1]),
            .t_out (jt[i+1])
        );
    end

    psed_cdiv #(
        .DIVISOR (psed_pkg::DIV_JERK)
    ) u_jerk_div (
        .clk     (clk),
        .en      (en),
        .num_in  (jp[3]),
        .quo_out (jerk_term)
    );

    // snap chain
    logic [DW-1:0] sp [0:4];
    logic [WW-1:0] st [0:4];

    assign sp[0] = {{(DW-WW){in_reg.seg_snap[WW-1]}}, in_reg.seg_snap};
    assign st[0] = in_reg.seg_duration;

    for (genvar i = 0; i < 4; i++)
    begin : g_snap
        psed_mul_step #(
            .SHIFT ((i < 2) ? psed_pkg::FRAC_SHIFT : 0)
        ) u_step (
            .clk   (clk),
            .en    (en),
            .p_in  (sp[i]),
            .t_in  (st[i]),
            .p_out (sp[i+1]),
            .t_out (st[i+1])
        );
    end

    psed_cdiv #(
        .DIVISOR (psed_pkg::DIV_SNAP)
    ) u_snap_div (
        .clk     (clk),
        .en      (en),
        .num_in  (sp[4]),
        .quo_out (snap_term)
    );

    // crackle chain
    logic [DW-1:0] cp [0:5];
    logic [WW-1:0] ct [0:5];

    assign cp[0] = {{(DW-WW){in_reg.seg_crackle[WW-1]}}, in_reg.seg_crackle};
    assign ct[0] = in_reg.seg_duration;

    for (genvar i = 0; i < 5; i++)
    begin : g_crk
        psed_mul_step #(
            .SHIFT ((i < 3) ? psed_pkg::FRAC_SHIFT : 0)
        ) u_step (
            .clk   (clk),
            .en    (en),
            .p_in  (cp[i]),
            .t_in  (ct[i]),
            .p_out (cp[i+1]),
            .t_out (ct[i+1])
        );
    end

    psed_cdiv #(
        .DIVISOR (psed_pkg::DIV_CRACKLE)
    ) u_crk_div (
        .clk     (clk),
        .en      (en),
        .num_in  (cp[5]),
        .quo_out (crk_term)
    );

    // align the shorter terms with the crackle term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel_dly_reg[0]  <= vel_reg;
            acc_dly_reg[0]  <= acc_term;
            jerk_dly_reg[0] <= jerk_term;
            snap_dly_reg[0] <= snap_term;
            for (int i = 1; i < VEL_DLY; i++)
            begin
                vel_dly_reg[i] <= vel_dly_reg[i-1];
            end
            for (int i = 1; i < ACC_DLY; i++)
            begin
                acc_dly_reg[i] <= acc_dly_reg[i-1];
            end
            for (int i = 1; i < JERK_DLY; i++)
            begin
                jerk_dly_reg[i] <= jerk_dly_reg[i-1];
            end
            for (int i = 1; i < SNAP_DLY; i++)
            begin
                snap_dly_reg[i] <= snap_dly_reg[i-1];
            end
        end
    end

    // three-stage sum, wraps at 64 bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg  <= vel_dly_reg[VEL_DLY-1] + acc_dly_reg[ACC_DLY-1];
            sb_reg  <= jerk_dly_reg[JERK_DLY-1] + snap_dly_reg[SNAP_DLY-1];
            sc_reg  <= crk_term;
            sd_reg  <= sa_reg + sb_reg;
            se_reg  <= sc_reg;
            out_reg <= sd_reg + se_reg;
        end
    end

    assign delta.valid          = vld_reg[OUT_AT];
    assign delta.data.end_delta = out_reg;

endmodule

@@ rtl/psed_mul_step.sv @@
module psed_mul_step #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [psed_pkg::DELTA_W-1:0]     p_in,
    input  logic [psed_pkg::WORD_W-1:0]      t_in,
    output logic [psed_pkg::DELTA_W-1:0]     p_out,
    output logic [psed_pkg::WORD_W-1:0]      t_out
);

    localparam int unsigned DW = psed_pkg::DELTA_W;
    localparam int unsigned WW = psed_pkg::WORD_W;
    localparam int unsigned PW = psed_pkg::PROD_W;

    logic          neg1_reg;
    logic [DW-1:0] mag_reg;
    logic [WW-1:0] t1_reg;

    logic          neg2_reg;
    logic [DW-1:0] pl_reg;
    logic [DW-1:0] ph_reg;
    logic [WW-1:0] t2_reg;

    logic          neg3_reg;
    logic [DW-1:0] res_reg;
    logic [WW-1:0] t3_reg;

    logic [DW-1:0] p4_reg;
    logic [WW-1:0] t4_reg;

    logic [DW-1:0] mag_next;
    logic [PW-1:0] full_prod;
    logic [DW-1:0] res_next;
    logic [DW-1:0] p4_next;

    assign mag_next  = p_in[DW-1] ? ('0 - p_in) : p_in;
    assign full_prod = {ph_reg, {WW{1'b0}}} + {{WW{1'b0}}, pl_reg};
    assign res_next  = full_prod[SHIFT +: DW];
    assign p4_next   = neg3_reg ? ('0 - res_reg) : res_reg;

    // magnitude, split product, recombine with shift, sign restore
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= p_in[DW-1];
            mag_reg  <= mag_next;
            t1_reg   <= t_in;

            neg2_reg <= neg1_reg;
            pl_reg   <= DW'(mag_reg[WW-1:0]) * DW'(t1_reg);
            ph_reg   <= DW'(mag_reg[DW-1:WW]) * DW'(t1_reg);
            t2_reg   <= t1_reg;

            neg3_reg <= neg2_reg;
            res_reg  <= res_next;
            t3_reg   <= t2_reg;

            p4_reg   <= p4_next;
            t4_reg   <= t3_reg;
        end
    end

    assign p_out = p4_reg;
    assign t_out = t4_reg;

endmodule

@@ rtl/psed_cdiv.sv @@
module psed_cdiv #(
    parameter int unsigned DIVISOR = 6
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [psed_pkg::DELTA_W-1:0] num_in,
    output logic [psed_pkg::DELTA_W-1:0] quo_out
);

    localparam int unsigned DW     = psed_pkg::DELTA_W;
    localparam int unsigned GW     = psed_pkg::DIV_DIGIT_W;
    localparam int unsigned DIGITS = psed_pkg::DIV_DIGITS;
    localparam int unsigned RW     = $clog2(DIVISOR);
    localparam int unsigned CW     = RW + 1;
    localparam logic [CW-1:0] DIV_C = CW'(DIVISOR);

    // restoring division of one digit, remainder carried between digits
    function automatic logic [RW+GW-1:0] div_digit(
        input logic [RW-1:0] rem_in,
        input logic [GW-1:0] bits
    );
        logic [CW-1:0] cur;
        logic [RW-1:0] rem;
        logic [GW-1:0] q;
        rem = rem_in;
        q   = '0;
        for (int i = GW - 1; i >= 0; i--)
        begin
            cur  = {rem, bits[i]};
            q[i] = (cur >= DIV_C);
            rem  = q[i] ? RW'(cur - DIV_C) : cur[RW-1:0];
        end
        return {rem, q};
    endfunction

    logic          neg_reg [0:DIGITS];
    logic [DW-1:0] num_reg [0:DIGITS];
    logic [RW-1:0] rem_reg [1:DIGITS-1];
    logic [RW-1:0] rem_in  [0:DIGITS-1];
    logic [RW+GW-1:0] dres [0:DIGITS-1];
    logic [DW-1:0] num_next [0:DIGITS-1];
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num_in[DW-1];
            num_reg[0] <= num_in[DW-1] ? ('0 - num_in) : num_in;
        end
    end

    // quotient digits replace dividend digits in place, msb first
    for (genvar g = 0; g < DIGITS; g++)
    begin : g_digit
        localparam int unsigned HI = DW - 1 - g * GW;
        localparam int unsigned LO = HI + 1 - GW;
        localparam logic [DW-1:0] DIGIT_MASK = DW'({GW{1'b1}}) << LO;

        if (g == 0)
        begin : g_first
            assign rem_in[g] = '0;
        end
        else
        begin : g_rest
            assign rem_in[g] = rem_reg[g];
        end

        assign dres[g]     = div_digit(rem_in[g], num_reg[g][HI -: GW]);
        assign num_next[g] = (num_reg[g] & ~DIGIT_MASK)
                           | (DW'(dres[g][GW-1:0]) << LO);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[g+1] <= neg_reg[g];
                num_reg[g+1] <= num_next[g];
            end
        end

        if (g < DIGITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= dres[g][RW+GW-1:GW];
                end
            end
        end
    end

    assign quo_next = neg_reg[DIGITS] ? ('0 - num_reg[DIGITS]) : num_reg[DIGITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo_out = quo_reg;

endmodule
